[src/segment_box_nearest_face_hit_top_assert.svh]
// assertion macros for the segment box face hit block
`ifndef SEGMENT_BOX_NEAREST_FACE_HIT_TOP_ASSERT_SVH
`define SEGMENT_BOX_NEAREST_FACE_HIT_TOP_ASSERT_SVH

// same cycle implication, sampled on clk, off during reset
`define SBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication, sampled on clk, off during reset
`define SBH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sbnfh_pkg.sv]
package sbnfh_pkg;

  localparam int FACES      = 6;
  localparam int LANES      = 12;
  localparam int AXES       = 3;
  localparam int DIV_STEPS  = 32;
  localparam int FRAC_STEPS = 17;
  localparam int SEL_LAST   = 10;

  localparam logic [16:0] FRAC_ONE = 17'd65536;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
  } div_t;

  typedef struct packed {
    logic [FACES-1:0]        cand;
    logic [FACES-1:0][32:0]  un;
    logic [FACES-1:0][32:0]  ud;
    logic [FACES-1:0][31:0]  plane;
    logic [LANES-1:0]        neg;
    logic [LANES-1:0][31:0]  st;
    logic [AXES-1:0][31:0]   lo;
    logic [AXES-1:0][31:0]   hi;
  } geo_t;

  typedef struct packed {
    geo_t                    g;
    logic [LANES-1:0][31:0]  lmag;
  } prep_t;

  typedef struct packed {
    geo_t              g;
    div_t [LANES-1:0]  cd;
    div_t [FACES-1:0]  fd;
  } work_t;

  typedef struct packed {
    logic [FACES-1:0]        cand;
    logic [FACES-1:0][32:0]  un;
    logic [FACES-1:0][32:0]  ud;
    logic [FACES-1:0][31:0]  plane;
    logic [LANES-1:0][31:0]  pt;
    logic [FACES-1:0][16:0]  frac;
    logic [AXES-1:0][31:0]   lo;
    logic [AXES-1:0][31:0]   hi;
  } rnd_t;

  typedef struct packed {
    logic [FACES-1:0]                   hit;
    logic [FACES-1:0][32:0]             un;
    logic [FACES-1:0][32:0]             ud;
    logic [FACES-1:0][AXES-1:0][31:0]   fpt;
    logic [FACES-1:0][16:0]             frac;
  } face_t;

  typedef struct packed {
    face_t        fc;
    logic         bv;
    logic [2:0]   bf;
    logic [32:0]  bn;
    logic [32:0]  bd;
    logic [65:0]  p_new;
    logic [65:0]  p_best;
  } sel_t;

  typedef struct packed {
    logic         hit_found;
    logic [31:0]  hit_x;
    logic [31:0]  hit_y;
    logic [31:0]  hit_z;
    logic [2:0]   hit_side;
    logic [16:0]  hit_frac;
  } res_t;

  function automatic logic [1:0] other_axis(input logic [1:0] k, input logic m);
    if (!m) begin
      return (k == 2'd0) ? 2'd1 : 2'd0;
    end
    return (k == 2'd2) ? 2'd1 : 2'd2;
  endfunction

  function automatic div_t div_step(input div_t d, input logic [32:0] ud);
    logic [32:0] cat;
    logic        ge;
    div_t        o;
    cat   = {d.rem, d.low[31]};
    ge    = (cat >= ud);
    o.rem = ge ? 32'(cat - ud) : cat[31:0];
    o.low = {d.low[30:0], ge};
    return o;
  endfunction

  function automatic logic [31:0] sat32(input logic [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      return v[31:0];
    end
    return v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

endpackage

[src/segment_box_nearest_face_hit_top.sv]
// a result passes through a_r, the dv_r divider stages, r_r, b_r, the sel_r chain and out_r before out_valid shows it
// throughput: one beat per cycle while in_stall is low; the 32-step lane dividers are pipelined
// in_stall rises only while the output skid stage holds a beat
// reset: synchronous rst_n clears all valid bits and the skid stage
`include "segment_box_nearest_face_hit_top_assert.svh"

module segment_box_nearest_face_hit_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_box_min_x,
  input  logic signed [31:0]  in_box_min_y,
  input  logic signed [31:0]  in_box_min_z,
  input  logic signed [31:0]  in_box_max_x,
  input  logic signed [31:0]  in_box_max_y,
  input  logic signed [31:0]  in_box_max_z,
  input  logic signed [31:0]  in_start_x,
  input  logic signed [31:0]  in_start_y,
  input  logic signed [31:0]  in_start_z,
  input  logic signed [31:0]  in_end_x,
  input  logic signed [31:0]  in_end_y,
  input  logic signed [31:0]  in_end_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit_found,
  output logic signed [31:0]  out_hit_x,
  output logic signed [31:0]  out_hit_y,
  output logic signed [31:0]  out_hit_z,
  output logic        [2:0]   out_hit_side,
  output logic        [16:0]  out_hit_fraction
);

  import sbnfh_pkg::*;

  logic [AXES-1:0][31:0] in_lo;
  logic [AXES-1:0][31:0] in_hi;
  logic [AXES-1:0][31:0] in_s;
  logic [AXES-1:0][31:0] in_e;

  logic                  en;
  logic                  out_take;

  logic                  a_v_r;
  prep_t                 a_r;
  prep_t                 a_nxt;
  logic [DIV_STEPS:0]    dv_v_r;
  work_t                 dv_r [0:DIV_STEPS];
  work_t                 dv0_nxt;
  work_t                 dv_nxt [1:DIV_STEPS];
  logic                  r_v_r;
  rnd_t                  r_r;
  rnd_t                  r_nxt;
  logic                  b_v_r;
  face_t                 b_r;
  face_t                 b_nxt;
  logic [SEL_LAST:0]     sel_v_r;
  sel_t                  sel_r [0:SEL_LAST];
  sel_t                  sel0_nxt;
  sel_t                  sel_nxt [1:SEL_LAST];
  res_t                  res_nxt;
  logic                  out_v_r;
  res_t                  out_r;
  logic                  sk_v_r;
  res_t                  sk_r;
  logic                  out_zero;
  logic                  out_legal;

  assign in_lo = {in_box_min_z, in_box_min_y, in_box_min_x};
  assign in_hi = {in_box_max_z, in_box_max_y, in_box_max_x};
  assign in_s  = {in_start_z, in_start_y, in_start_x};
  assign in_e  = {in_end_z, in_end_y, in_end_x};

  assign en       = !sk_v_r;
  assign in_stall = sk_v_r;
  assign out_take = !out_v_r || !out_stall;

  // face setup: plane offsets, straddle test, lane deltas
  always_comb begin
    logic signed [31:0] p_v;
    logic signed [31:0] sk_v;
    logic signed [31:0] ek_v;
    logic signed [32:0] n_v;
    logic signed [32:0] d_v;
    logic signed [32:0] l_v;
    logic        [1:0]  k_v;
    logic        [1:0]  j_v;
    a_nxt      = '0;
    a_nxt.g.lo = in_lo;
    a_nxt.g.hi = in_hi;
    for (int f = 0; f < FACES; f++) begin
      k_v  = 2'(f >> 1);
      p_v  = ((f & 1) != 0) ? $signed(in_hi[k_v]) : $signed(in_lo[k_v]);
      sk_v = $signed(in_s[k_v]);
      ek_v = $signed(in_e[k_v]);
      n_v  = 33'(p_v) - 33'(sk_v);
      d_v  = 33'(ek_v) - 33'(sk_v);
      a_nxt.g.cand[f]  = ((sk_v <= p_v && ek_v >= p_v) || (sk_v >= p_v && ek_v <= p_v)) &&
                         (d_v != 33'sd0);
      a_nxt.g.un[f]    = n_v[32] ? 33'(-n_v) : 33'(n_v);
      a_nxt.g.ud[f]    = d_v[32] ? 33'(-d_v) : 33'(d_v);
      a_nxt.g.plane[f] = p_v;
      for (int m = 0; m < 2; m++) begin
        j_v = other_axis(k_v, 1'(m));
        l_v = 33'($signed(in_e[j_v])) - 33'($signed(in_s[j_v]));
        a_nxt.g.neg[2*f+m] = l_v[32];
        a_nxt.g.st[2*f+m]  = in_s[j_v];
        a_nxt.lmag[2*f+m]  = l_v[32] ? 32'(-l_v) : 32'(l_v);
      end
    end
  end

  // products and divider seeds
  always_comb begin
    logic [64:0] pr_v;
    dv0_nxt   = '0;
    dv0_nxt.g = a_r.g;
    for (int c = 0; c < LANES; c++) begin
      pr_v = 65'(a_r.g.un[c >> 1]) * 65'(a_r.lmag[c]);
      dv0_nxt.cd[c].rem = pr_v[63:32];
      dv0_nxt.cd[c].low = pr_v[31:0];
    end
    for (int f = 0; f < FACES; f++) begin
      dv0_nxt.fd[f].rem = a_r.g.un[f][32:1];
      dv0_nxt.fd[f].low = {a_r.g.un[f][0], 31'b0};
    end
  end

  // one quotient bit per stage; the face fraction dividers step only in the first FRAC_STEPS stages
  always_comb begin
    for (int i = 1; i <= DIV_STEPS; i++) begin
      dv_nxt[i] = dv_r[i-1];
      for (int c = 0; c < LANES; c++) begin
        dv_nxt[i].cd[c] = div_step(dv_r[i-1].cd[c], dv_r[i-1].g.ud[c >> 1]);
      end
      if (i <= FRAC_STEPS) begin
        for (int f = 0; f < FACES; f++) begin
          dv_nxt[i].fd[f] = div_step(dv_r[i-1].fd[f], dv_r[i-1].g.ud[f]);
        end
      end
    end
  end

  // rounding, sign and saturation
  always_comb begin
    logic        rb_v;
    logic [32:0] qr_v;
    logic [33:0] v_v;
    logic [17:0] fq_v;
    r_nxt       = '0;
    r_nxt.cand  = dv_r[DIV_STEPS].g.cand;
    r_nxt.un    = dv_r[DIV_STEPS].g.un;
    r_nxt.ud    = dv_r[DIV_STEPS].g.ud;
    r_nxt.plane = dv_r[DIV_STEPS].g.plane;
    r_nxt.lo    = dv_r[DIV_STEPS].g.lo;
    r_nxt.hi    = dv_r[DIV_STEPS].g.hi;
    for (int c = 0; c < LANES; c++) begin
      rb_v = ({dv_r[DIV_STEPS].cd[c].rem, 1'b0} >= dv_r[DIV_STEPS].g.ud[c >> 1]);
      qr_v = {1'b0, dv_r[DIV_STEPS].cd[c].low} + {32'b0, rb_v};
      if (dv_r[DIV_STEPS].g.neg[c]) begin
        v_v = 34'($signed(dv_r[DIV_STEPS].g.st[c])) - {1'b0, qr_v};
      end else begin
        v_v = 34'($signed(dv_r[DIV_STEPS].g.st[c])) + {1'b0, qr_v};
      end
      r_nxt.pt[c] = sat32(v_v);
    end
    for (int f = 0; f < FACES; f++) begin
      rb_v = ({dv_r[DIV_STEPS].fd[f].rem, 1'b0} >= dv_r[DIV_STEPS].g.ud[f]);
      fq_v = {1'b0, dv_r[DIV_STEPS].fd[f].low[16:0]} + {17'b0, rb_v};
      r_nxt.frac[f] = (fq_v > {1'b0, FRAC_ONE}) ? FRAC_ONE : fq_v[16:0];
    end
  end

  // face bounds check
  always_comb begin
    logic [1:0] k_v;
    logic [1:0] j_v;
    logic [1:0] in_v;
    b_nxt      = '0;
    b_nxt.un   = r_r.un;
    b_nxt.ud   = r_r.ud;
    b_nxt.frac = r_r.frac;
    for (int f = 0; f < FACES; f++) begin
      k_v = 2'(f >> 1);
      b_nxt.fpt[f][k_v] = r_r.plane[f];
      for (int m = 0; m < 2; m++) begin
        j_v = other_axis(k_v, 1'(m));
        b_nxt.fpt[f][j_v] = r_r.pt[2*f+m];
        in_v[m] = ($signed(r_r.pt[2*f+m]) >= $signed(r_r.lo[j_v])) &&
                  ($signed(r_r.pt[2*f+m]) <= $signed(r_r.hi[j_v]));
      end
      b_nxt.hit[f] = r_r.cand[f] && in_v[0] && in_v[1];
    end
  end

  // nearest face chain: cross products, then compare and keep
  always_comb begin
    sel0_nxt    = '0;
    sel0_nxt.fc = b_r;
    sel0_nxt.bv = b_r.hit[0];
    sel0_nxt.bn = b_r.un[0];
    sel0_nxt.bd = b_r.ud[0];
    for (int t = 1; t <= SEL_LAST; t++) begin
      sel_nxt[t] = sel_r[t-1];
      if ((t & 1) != 0) begin
        sel_nxt[t].p_new  = 66'(sel_r[t-1].fc.un[(t+1) >> 1]) * 66'(sel_r[t-1].bd);
        sel_nxt[t].p_best = 66'(sel_r[t-1].bn) * 66'(sel_r[t-1].fc.ud[(t+1) >> 1]);
      end else if (sel_r[t-1].fc.hit[t >> 1] &&
                   (!sel_r[t-1].bv || sel_r[t-1].p_new < sel_r[t-1].p_best)) begin
        sel_nxt[t].bv = 1'b1;
        sel_nxt[t].bf = 3'(t >> 1);
        sel_nxt[t].bn = sel_r[t-1].fc.un[t >> 1];
        sel_nxt[t].bd = sel_r[t-1].fc.ud[t >> 1];
      end
    end
  end

  always_comb begin
    res_nxt = '0;
    if (sel_r[SEL_LAST].bv) begin
      res_nxt.hit_found = 1'b1;
      res_nxt.hit_side  = sel_r[SEL_LAST].bf;
      for (int f = 0; f < FACES; f++) begin
        if (sel_r[SEL_LAST].bf == 3'(f)) begin
          res_nxt.hit_x    = sel_r[SEL_LAST].fc.fpt[f][0];
          res_nxt.hit_y    = sel_r[SEL_LAST].fc.fpt[f][1];
          res_nxt.hit_z    = sel_r[SEL_LAST].fc.fpt[f][2];
          res_nxt.hit_frac = sel_r[SEL_LAST].fc.frac[f];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      dv_v_r  <= '0;
      r_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      sel_v_r <= '0;
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      if (en) begin
        a_v_r   <= in_valid;
        dv_v_r  <= {dv_v_r[DIV_STEPS-1:0], a_v_r};
        r_v_r   <= dv_v_r[DIV_STEPS];
        b_v_r   <= r_v_r;
        sel_v_r <= {sel_v_r[SEL_LAST-1:0], b_v_r};
      end
      if (out_take) begin
        out_v_r <= sk_v_r || (en && sel_v_r[SEL_LAST]);
        sk_v_r  <= 1'b0;
      end else if (en && sel_v_r[SEL_LAST]) begin
        sk_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_nxt;
      dv_r[0]  <= dv0_nxt;
      for (int i = 1; i <= DIV_STEPS; i++) begin
        dv_r[i] <= dv_nxt[i];
      end
      r_r      <= r_nxt;
      b_r      <= b_nxt;
      sel_r[0] <= sel0_nxt;
      for (int t = 1; t <= SEL_LAST; t++) begin
        sel_r[t] <= sel_nxt[t];
      end
    end
    if (out_take) begin
      out_r <= sk_v_r ? sk_r : res_nxt;
    end else if (en) begin
      sk_r <= res_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_hit_found    = out_r.hit_found;
  assign out_hit_x        = $signed(out_r.hit_x);
  assign out_hit_y        = $signed(out_r.hit_y);
  assign out_hit_z        = $signed(out_r.hit_z);
  assign out_hit_side     = out_r.hit_side;
  assign out_hit_fraction = out_r.hit_frac;

  assign out_zero  = out_r.hit_x == 32'd0 && out_r.hit_y == 32'd0 && out_r.hit_z == 32'd0 &&
                     out_r.hit_side == 3'd0 && out_r.hit_frac == 17'd0;
  assign out_legal = out_r.hit_frac <= FRAC_ONE && out_r.hit_side <= 3'd5;

  `SBH_ASSERT_IMP(a_skid_needs_out, sk_v_r, out_v_r, "skid beat held while output empty")
  `SBH_ASSERT_IMP(a_skid_load, $rose(sk_v_r), $past(out_v_r && out_stall), "skid loaded early")
  `SBH_ASSERT_NXT(a_skid_drain, sk_v_r && !out_stall, !sk_v_r && out_v_r, "skid beat stuck")
  `SBH_ASSERT_IMP(a_miss_zero, out_v_r && !out_r.hit_found, out_zero, "miss with nonzero fields")
  `SBH_ASSERT_IMP(a_hit_range, out_v_r && out_r.hit_found, out_legal, "hit fields out of range")

endmodule

[tb/segment_box_nearest_face_hit_top_tb.sv]
module segment_box_nearest_face_hit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 48;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic signed [31:0] s_x, s_y, s_z, e_x, e_y, e_z;
  } query_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] x, y, z;
    logic [2:0]         side;
    logic [16:0]        frac;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  query_t cur = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit_found;
  logic signed [31:0] out_hit_x, out_hit_y, out_hit_z;
  logic [2:0] out_hit_side;
  logic [16:0] out_hit_fraction;

  query_t pending_q[$];
  hit_t   expected_hits[$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  int     send_gap = 0;
  int     recv_gap = 0;
  int     hold_cycles = 0;
  bit     gaps_on = 1'b1;
  bit     sender_paused = 1'b0;
  bit     stim_done = 1'b0;

  always #4 clk = ~clk;

  segment_box_nearest_face_hit_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_box_min_x(cur.lo_x), .in_box_min_y(cur.lo_y), .in_box_min_z(cur.lo_z),
    .in_box_max_x(cur.hi_x), .in_box_max_y(cur.hi_y), .in_box_max_z(cur.hi_z),
    .in_start_x(cur.s_x), .in_start_y(cur.s_y), .in_start_z(cur.s_z),
    .in_end_x(cur.e_x), .in_end_y(cur.e_y), .in_end_z(cur.e_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit_found(out_hit_found), .out_hit_x(out_hit_x), .out_hit_y(out_hit_y),
    .out_hit_z(out_hit_z), .out_hit_side(out_hit_side),
    .out_hit_fraction(out_hit_fraction)
  );

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // one face; returns crossing point and t = num/den on a hit
  function automatic bit cross_face(int k, longint p, longint s[3], longint e[3],
                                    longint lo[3], longint hi[3], output longint pt[3],
                                    output longint unsigned num,
                                    output longint unsigned den);
    longint n, d, l, v;
    longint unsigned pr, q, r;
    pt = '{0, 0, 0};
    num = 0;
    den = 1;
    if (!((s[k] <= p && e[k] >= p) || (s[k] >= p && e[k] <= p))) return 0;
    d = e[k] - s[k];
    if (d == 0) return 0;
    n = p - s[k];
    num = abs64(n);
    den = abs64(d);
    for (int j = 0; j < 3; j++) begin
      if (j == k) begin
        pt[j] = p;
      end else begin
        l = e[j] - s[j];
        pr = num * abs64(l);
        q = pr / den;
        r = pr % den;
        if (r >= den - r) q++;
        v = (l < 0) ? s[j] - longint'(q) : s[j] + longint'(q);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        pt[j] = v;
        if (v < lo[j] || v > hi[j]) return 0;
      end
    end
    return 1;
  endfunction

  function automatic hit_t nearest_hit(query_t qi);
    longint lo[3], hi[3], s[3], e[3], pt[3], bp[3];
    longint unsigned tn, td, bn, bd, q, r, num;
    int best;
    hit_t h;
    lo = '{qi.lo_x, qi.lo_y, qi.lo_z};
    hi = '{qi.hi_x, qi.hi_y, qi.hi_z};
    s  = '{qi.s_x, qi.s_y, qi.s_z};
    e  = '{qi.e_x, qi.e_y, qi.e_z};
    best = -1;
    bn = 0;
    bd = 1;
    bp = '{0, 0, 0};
    h = '0;
    for (int f = 0; f < 6; f++) begin
      if (cross_face(f >> 1, (f & 1) ? hi[f >> 1] : lo[f >> 1], s, e, lo, hi,
                     pt, tn, td)) begin
        if (best < 0 || tn * bd < bn * td) begin
          best = f;
          bn = tn;
          bd = td;
          bp = pt;
        end
      end
    end
    if (best < 0) return h;
    num = bn << 16;
    q = num / bd;
    r = num % bd;
    if (r >= bd - r) q++;
    if (q > 65536) q = 65536;
    h.found = 1'b1;
    h.x = bp[0][31:0];
    h.y = bp[1][31:0];
    h.z = bp[2][31:0];
    h.side = best[2:0];
    h.frac = q[16:0];
    return h;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 40)) - 20 <<< 16;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t qi;
    int mode;
    logic [31:0] a, b;
    mode = $urandom_range(0, 9);
    mode = (mode == 0) ? 0 : (mode < 6) ? 1 : 2;
    a = rand_coord(mode); b = rand_coord(mode);
    {qi.lo_x, qi.hi_x} = ($signed(a) <= $signed(b) || mode == 0) ? {a, b} : {b, a};
    a = rand_coord(mode); b = rand_coord(mode);
    {qi.lo_y, qi.hi_y} = ($signed(a) <= $signed(b) || mode == 0) ? {a, b} : {b, a};
    a = rand_coord(mode); b = rand_coord(mode);
    {qi.lo_z, qi.hi_z} = ($signed(a) <= $signed(b) || mode == 0) ? {a, b} : {b, a};
    qi.s_x = rand_coord(mode); qi.s_y = rand_coord(mode); qi.s_z = rand_coord(mode);
    qi.e_x = rand_coord(mode); qi.e_y = rand_coord(mode); qi.e_z = rand_coord(mode);
    // often snap an end onto a face plane or make an axis parallel
    case ($urandom_range(0, 5))
      0: qi.e_x = qi.lo_x;
      1: qi.s_y = qi.hi_y;
      2: qi.e_z = qi.s_z;
      default: ;
    endcase
    return qi;
  endfunction

  function automatic query_t make_query(int lx, int ly, int lz, int hx, int hy, int hz,
                                        int sx, int sy, int sz, int ex, int ey, int ez);
    query_t qi;
    qi = '{lx, ly, lz, hx, hy, hz, sx, sy, sz, ex, ey, ez};
    return qi;
  endfunction

  // driver
  always @(posedge clk) begin
    int gap_v;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_hits.push_back(nearest_hit(cur));
        gap_v = gaps_on ? $urandom_range(0, 11) : 0;
        if (gap_v == 0 && pending_q.size() > 0 && !sender_paused) begin
          cur <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
          send_gap <= (gap_v > 0) ? gap_v - 1 : 0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_q.size() > 0 && !sender_paused) begin
          cur <= pending_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    hit_t exp_h, got;
    int gap_v;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_hit_found, out_hit_x, out_hit_y, out_hit_z, out_hit_side,
                out_hit_fraction};
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", got);
        end else begin
          exp_h = expected_hits.pop_front();
          if (got !== exp_h) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch expected %p actual %p", exp_h, got);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        gap_v = gaps_on ? $urandom_range(0, 11) : 0;
        recv_gap <= (gap_v > 0) ? gap_v - 1 : 0;
        out_stall <= (gap_v > 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || hold_cycles > 0
        || (pending_q.size() == 0 && expected_hits.size() == 0 && !in_valid)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL segment_box_nearest_face_hit_top");
        $finish;
      end
    end
  end

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: hits on each face, parallel, zero length, inverted, extremes, touch
    pending_q.push_back(make_query(0, 0, 0, 65536, 65536, 65536, -65536, 32768, 32768,
                                   131072, 32768, 32768));
    pending_q.push_back(make_query(0, 0, 0, 65536, 65536, 65536, 131072, 32768, 32768,
                                   -65536, 32768, 32768));
    pending_q.push_back(make_query(0, 0, 0, 65536, 65536, 65536, 32768, -65536, 32768,
                                   32768, 131072, 32768));
    pending_q.push_back(make_query(0, 0, 0, 65536, 65536, 65536, 32768, 131072, 32768,
                                   32768, -65536, 32768));
    pending_q.push_back(make_query(0, 0, 0, 65536, 65536, 65536, 32768, 32768, -65536,
                                   32768, 32768, 131072));
    pending_q.push_back(make_query(0, 0, 0, 65536, 65536, 65536, 32768, 32768, 131072,
                                   32768, 32768, -65536));
    pending_q.push_back(make_query(0, 0, 0, 65536, 65536, 65536, 5, 5, 5, 5, 5, 5));
    pending_q.push_back(make_query(0, 0, 0, 65536, 65536, 65536, -100, 5, 5, -100, 9, 9));
    pending_q.push_back(make_query(65536, 0, 0, 0, 65536, 65536, -65536, 5, 5,
                                   131072, 5, 5));
    pending_q.push_back(make_query(0, 0, 0, 65536, 65536, 65536, 0, 0, 0, 65536, 65536,
                                   65536));
    pending_q.push_back(make_query(0, 0, 0, 65536, 65536, 65536, -65536, 0, 0, 0, 0, 0));
    pending_q.push_back(make_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                   32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                   32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_q.push_back(make_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                   0, 32'h80000000, 32'h7fffffff, 1));
    pending_q.push_back(make_query(-1, -1, -1, -1, -1, -1, 32'h7fffffff, -1, -1,
                                   32'h80000000, -1, -1));
    pending_q.push_back(make_query(0, 0, 0, 3, 3, 3, -1, 0, 0, 2, 3, 1));
    pending_q.push_back(make_query(0, 0, 0, 3, 3, 3, -3, 1, 1, 6, 2, 2));
    pending_q.push_back(make_query(0, 0, 0, 10, 10, 10, -5, -5, 3, 5, 5, 3));
    pending_q.push_back(make_query(32'h55555555, 32'haaaaaaaa, 0, 32'haaaaaaaa,
                                   32'h55555555, 0, 32'h0f0f0f0f, 32'hf0f0f0f0, 0,
                                   32'hf0f0f0f0, 32'h0f0f0f0f, 1));
    for (int i = 0; i < 400; i++) pending_q.push_back(rand_query());
    n = pending_q.size();
    // one long receiver hold while the sender keeps offering
    wait (pending_q.size() < n - 60);
    @(posedge clk);
    hold_cycles <= 300;
    gaps_on <= 1'b0;
    wait (hold_cycles == 0);
    @(posedge clk);
    gaps_on <= 1'b1;
    // sender pauses until the pipe drains
    wait (pending_q.size() < n - 200);
    @(posedge clk);
    sender_paused <= 1'b1;
    wait (!in_valid && expected_hits.size() == 0);
    @(posedge clk);
    sender_paused <= 1'b0;
    // a stretch without idling
    wait (pending_q.size() < n - 300);
    @(posedge clk);
    gaps_on <= 1'b0;
    wait (pending_q.size() < n - 360);
    @(posedge clk);
    gaps_on <= 1'b1;
    wait (pending_q.size() == 0 && !in_valid && expected_hits.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("PASS segment_box_nearest_face_hit_top");
    end else begin
      $display("FAIL segment_box_nearest_face_hit_top");
    end
    $finish;
  end

endmodule

[segment_box_nearest_face_hit_top.f]
+incdir+src
src/sbnfh_pkg.sv
src/segment_box_nearest_face_hit_top.sv
tb/segment_box_nearest_face_hit_top_tb.sv
